@@ rtl/core/baro_temp_pressure_compensation_defines.svh @@
// Assertion macros shared by the checker of the compensation block.
// No dependencies; clock clk_i and active-low reset rst_ni are assumed in scope.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Property checked only outside reset.
`define BTPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btpc check failed");

// Property checked at every edge, reset included.
`define BTPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("btpc check failed");

`endif

@@ rtl/core/btpc_pkg.sv @@
// Package of the barometric compensation block: widths, latencies, register codes.
// No dependencies.
`default_nettype none

package btpc_pkg;

  localparam int unsigned DW      = 64;   // wrap width of pressure math
  localparam int unsigned RAW_W   = 20;
  localparam int unsigned REM_W   = 31;   // divisor magnitude is at most 2^30
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Reciprocal of 100 scaled by 2^34, rounded up; exact for magnitudes below 2^30.
  localparam logic [27:0] RECIP100   = 28'd171798692;
  localparam int unsigned RECIP_SH   = 34;
  localparam logic [DW-1:0] FINE_OFS = 64'd128000;
  localparam logic [DW-1:0] PRESS_SCALE = 64'd3125;

  // Pipeline timing, counted in register stages from the accepting edge.
  localparam int unsigned LAT_TEMP  = 8;
  localparam int unsigned LAT_TOTAL = 85;
  localparam int unsigned TEMP_DLY  = LAT_TOTAL - LAT_TEMP;
  localparam int unsigned PP_DLY    = 10;
  localparam int unsigned DZ_DLY    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_CALIB,
    CFG_PRESS_LO,
    CFG_PRESS_HI,
    CFG_PRESS_P9
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [25:0] deg;
  } temp_res_t;

  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    return {{(DW-16){v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/btpc_mul.sv @@
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product.
// Built from three 32 x 32 partial products; depends on btpc_pkg.
`default_nettype none

module btpc_mul import btpc_pkg::*; #(
  parameter int unsigned TW = DW
) (
  input  logic          clk_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic [TW-1:0] tag_i,
  output logic [DW-1:0] p_o,
  output logic [TW-1:0] tag_o
);

  localparam int unsigned HW = DW / 2;

  logic [DW-1:0] ll_d, ll_q;
  logic [HW-1:0] lh_d, lh_q, hl_d, hl_q;
  logic [HW-1:0] mid_sum;
  logic [DW-1:0] p_d, p_q;
  logic [TW-1:0] tag1_q, tag2_q;

  assign ll_d = a_i[HW-1:0] * b_i[HW-1:0];
  assign lh_d = a_i[HW-1:0] * b_i[DW-1:HW];
  assign hl_d = a_i[DW-1:HW] * b_i[HW-1:0];

  // high partials only reach the upper half of the wrapped product
  assign mid_sum = lh_q + hl_q;
  assign p_d     = ll_q + {mid_sum, {HW{1'b0}}};

  always_ff @(posedge clk_i) begin
    ll_q   <= ll_d;
    lh_q   <= lh_d;
    hl_q   <= hl_d;
    tag1_q <= tag_i;
    p_q    <= p_d;
    tag2_q <= tag1_q;
  end

  assign p_o   = p_q;
  assign tag_o = tag2_q;

endmodule

`default_nettype wire

@@ rtl/core/btpc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Unsigned 64-bit dividend by a 31-bit divisor; depends on btpc_pkg.
`default_nettype none

module btpc_div import btpc_pkg::*; #(
  parameter int unsigned TW = 2
) (
  input  logic             clk_i,
  input  logic [DW-1:0]    num_i,
  input  logic [REM_W-1:0] den_i,
  input  logic [TW-1:0]    tag_i,
  output logic [DW-1:0]    quo_o,
  output logic [TW-1:0]    tag_o
);

  logic [REM_W-1:0] rem_q [DW];
  logic [DW-1:0]    qn_q  [DW];
  logic [REM_W-1:0] md_q  [DW-1];
  logic [TW-1:0]    tag_q [DW];

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [REM_W-1:0] r_in;
    logic [DW-1:0]    q_in;
    logic [REM_W-1:0] m_in;
    logic [TW-1:0]    t_in;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign q_in = num_i;
      assign m_in = den_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign q_in = qn_q[i-1];
      assign m_in = md_q[i-1];
      assign t_in = tag_q[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_in, q_in[DW-1]};
    assign diff  = trial - {1'b0, m_in};
    assign ge    = trial >= {1'b0, m_in};

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      qn_q[i]  <= {q_in[DW-2:0], ge};
      tag_q[i] <= t_in;
    end

    if (i < DW - 1) begin : g_md
      always_ff @(posedge clk_i) begin
        md_q[i] <= m_in;
      end
    end
  end

  assign quo_o = qn_q[DW-1];
  assign tag_o = tag_q[DW-1];

endmodule

`default_nettype wire

@@ rtl/core/btpc_temp.sv @@
// Temperature path: fine temperature, hundredths and whole degrees, 8 stages.
// Fine temperature is also tapped after stage 4 for the pressure path; uses btpc_pkg.
`default_nettype none

module btpc_temp import btpc_pkg::*; (
  input  logic             clk_i,
  input  logic [RAW_W-1:0] raw_temp_i,
  input  logic [47:0]      temp_calib_i,
  output logic [31:0]      fine_early_o,
  output temp_res_t        res_o
);

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;

  logic signed [17:0] x1_d, x1_q;
  logic signed [16:0] dt_d, dt_q;
  logic signed [33:0] m1_q, dd_q;
  logic signed [22:0] a3_q;
  logic signed [37:0] m2_q;
  logic signed [24:0] fsum;
  logic        [31:0] fine4_q, fine5_q, fine6_q, fine7_q, fine8_q;
  logic signed [34:0] f35, v35;
  logic signed [26:0] centi5_q, centi6_q, centi7_q, centi8_q;
  logic        [26:0] mag6_q;
  logic               neg6_q, neg7_q;
  logic        [54:0] qm7_q;
  logic        [25:0] q26, deg8_q;

  assign t1 = temp_calib_i[15:0];
  assign t2 = $signed(temp_calib_i[31:16]);
  assign t3 = $signed(temp_calib_i[47:32]);

  assign x1_d = $signed({1'b0, raw_temp_i[RAW_W-1:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt_d = $signed({1'b0, raw_temp_i[RAW_W-1:4]}) - $signed({1'b0, t1});

  assign fsum = 25'(a3_q) + 25'(m2_q >>> 14);

  assign f35 = 35'(signed'(fine4_q));
  assign v35 = (f35 <<< 2) + f35 + 35'sd128;

  assign q26 = 26'(qm7_q[54:RECIP_SH]);

  always_ff @(posedge clk_i) begin
    x1_q     <= x1_d;
    dt_q     <= dt_d;
    m1_q     <= x1_q * t2;
    dd_q     <= dt_q * dt_q;
    a3_q     <= 23'(m1_q >>> 11);
    m2_q     <= $signed(dd_q[33:12]) * t3;
    fine4_q  <= 32'(fsum);
    centi5_q <= v35[34:8];
    fine5_q  <= fine4_q;
    neg6_q   <= centi5_q[26];
    mag6_q   <= centi5_q[26] ? 27'(-centi5_q) : 27'(centi5_q);
    centi6_q <= centi5_q;
    fine6_q  <= fine5_q;
    qm7_q    <= mag6_q * RECIP100;
    neg7_q   <= neg6_q;
    centi7_q <= centi6_q;
    fine7_q  <= fine6_q;
    deg8_q   <= neg7_q ? -q26 : q26;
    centi8_q <= centi7_q;
    fine8_q  <= fine7_q;
  end

  assign fine_early_o = fine4_q;
  assign res_o.fine   = fine8_q;
  assign res_o.centi  = 32'(centi8_q);
  assign res_o.deg    = deg8_q;

endmodule

`default_nettype wire

@@ rtl/core/baro_temp_pressure_compensation.sv @@
// Top level of the barometric temperature and pressure compensation pipeline.
// Uses btpc_pkg, btpc_temp, btpc_mul and btpc_div.
//
// channel   direction  handshake               payload
// request   in         start & !busy           raw_temp_i, raw_pressure_i
// result    out        done_o (one cycle)      fine_temp_o .. div_zero_o
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A request may enter every cycle; busy stays low.
// Each result passes through the 64-stage divider and the multiplier stages
// around it; results leave in request order.
// Reset clears the valid chain and the calibration registers; nothing stalls.
`default_nettype none

module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [RAW_W-1:0]     raw_temp_i,
  input  logic [RAW_W-1:0]     raw_pressure_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [31:0]          fine_temp_o,
  output logic [31:0]          temp_centi_o,
  output logic [25:0]          temp_deg_o,
  output logic [31:0]          pressure_q24_8_o,
  output logic                 div_zero_o
);

  logic accept;
  logic [LAT_TOTAL-1:0] vld_d, vld_q;

  logic [47:0] temp_calib_q;
  logic [63:0] press_lo_q, press_hi_q;
  logic [15:0] p9_q;

  logic [DW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic [31:0]   fine4;
  temp_res_t     tres8;
  temp_res_t     tdly_q [TEMP_DLY];
  logic [20:0]   pp_q [PP_DLY];

  logic [DW-1:0] pa5_q;
  logic [DW-1:0] aa7, ap5_7, ap2_7, b1_9, a3_9, ap5_9, ap2_9;
  logic [DW-1:0] b10_q, a10_q, num11_q, a11_q;
  logic [DW-1:0] num13, den13;
  logic [DW-1:0] mn14_q;
  logic [REM_W-1:0] md14_q, den_s;
  logic          neg14_q, dz14_q;
  logic [DW-1:0] quo78;
  logic [1:0]    tag78;
  logic [DW-1:0] p79_q, s79;
  logic [DW-1:0] ps81, s81, pb81, p81, t83, pb83, p83;
  logic [DW-1:0] sum84_q;
  logic [DZ_DLY-1:0] dz_q;
  logic [31:0]   p7sh, pr85_q;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign vld_d  = {vld_q[LAT_TOTAL-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      temp_calib_q <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      p9_q         <= '0;
    end else begin
      vld_q <= vld_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_TEMP_CALIB: temp_calib_q <= cfg_wdata_i[47:0];
          CFG_PRESS_LO:   press_lo_q   <= cfg_wdata_i;
          CFG_PRESS_HI:   press_hi_q   <= cfg_wdata_i;
          CFG_PRESS_P9:   p9_q         <= cfg_wdata_i[15:0];
          default:        ;
        endcase
      end
    end
  end

  assign p1 = {{(DW-16){1'b0}}, press_lo_q[15:0]};
  assign p2 = sx16(press_lo_q[31:16]);
  assign p3 = sx16(press_lo_q[47:32]);
  assign p4 = sx16(press_lo_q[63:48]);
  assign p5 = sx16(press_hi_q[15:0]);
  assign p6 = sx16(press_hi_q[31:16]);
  assign p7 = sx16(press_hi_q[47:32]);
  assign p8 = sx16(press_hi_q[63:48]);
  assign p9 = sx16(p9_q);

  btpc_temp u_temp (
    .clk_i        (clk_i),
    .raw_temp_i   (raw_temp_i),
    .temp_calib_i (temp_calib_q),
    .fine_early_o (fine4),
    .res_o        (tres8)
  );

  // square and first-order terms in the fine temperature offset
  btpc_mul #(.TW(1)) u_mul_aa (
    .clk_i (clk_i), .a_i (pa5_q), .b_i (pa5_q), .tag_i (1'b0), .p_o (aa7), .tag_o ()
  );
  btpc_mul #(.TW(1)) u_mul_ap5 (
    .clk_i (clk_i), .a_i (pa5_q), .b_i (p5), .tag_i (1'b0), .p_o (ap5_7), .tag_o ()
  );
  btpc_mul #(.TW(1)) u_mul_ap2 (
    .clk_i (clk_i), .a_i (pa5_q), .b_i (p2), .tag_i (1'b0), .p_o (ap2_7), .tag_o ()
  );

  btpc_mul #(.TW(DW)) u_mul_b1 (
    .clk_i (clk_i), .a_i (aa7), .b_i (p6), .tag_i (ap5_7), .p_o (b1_9), .tag_o (ap5_9)
  );
  btpc_mul #(.TW(DW)) u_mul_a3 (
    .clk_i (clk_i), .a_i (aa7), .b_i (p3), .tag_i (ap2_7), .p_o (a3_9), .tag_o (ap2_9)
  );

  btpc_mul #(.TW(1)) u_mul_num (
    .clk_i (clk_i), .a_i (num11_q), .b_i (PRESS_SCALE), .tag_i (1'b0),
    .p_o (num13), .tag_o ()
  );
  btpc_mul #(.TW(1)) u_mul_den (
    .clk_i (clk_i), .a_i (a11_q), .b_i (p1), .tag_i (1'b0), .p_o (den13), .tag_o ()
  );

  assign den_s = den13[DW-1:DW-REM_W];

  btpc_div #(.TW(2)) u_div (
    .clk_i (clk_i),
    .num_i (mn14_q),
    .den_i (md14_q),
    .tag_i ({neg14_q, dz14_q}),
    .quo_o (quo78),
    .tag_o (tag78)
  );

  assign s79 = DW'($signed(p79_q) >>> 13);

  btpc_mul #(.TW(DW)) u_mul_ps (
    .clk_i (clk_i), .a_i (s79), .b_i (p9), .tag_i (s79), .p_o (ps81), .tag_o (s81)
  );
  btpc_mul #(.TW(DW)) u_mul_pb (
    .clk_i (clk_i), .a_i (p79_q), .b_i (p8), .tag_i (p79_q), .p_o (pb81), .tag_o (p81)
  );
  btpc_mul #(.TW(2*DW)) u_mul_t (
    .clk_i (clk_i), .a_i (ps81), .b_i (s81), .tag_i ({pb81, p81}),
    .p_o (t83), .tag_o ({pb83, p83})
  );

  assign p7sh = {p7[27:0], 4'b0000};

  always_ff @(posedge clk_i) begin
    pp_q[0] <= 21'h100000 - {1'b0, raw_pressure_i};
    for (int i = 1; i < PP_DLY; i++) begin
      pp_q[i] <= pp_q[i-1];
    end

    pa5_q <= {{(DW-32){fine4[31]}}, fine4} - FINE_OFS;

    b10_q <= b1_9 + {ap5_9[DW-18:0], 17'd0} + {p4[DW-36:0], 35'd0};
    a10_q <= DW'($signed(a3_9) >>> 8) + {ap2_9[DW-13:0], 12'd0} + (DW'(1) << 47);

    num11_q <= {{(DW-52){1'b0}}, pp_q[PP_DLY-1], 31'd0} - b10_q;
    a11_q   <= a10_q;

    // signs, magnitudes and zero flag for the unsigned divider
    mn14_q  <= num13[DW-1] ? -num13 : num13;
    md14_q  <= den13[DW-1] ? -den_s : den_s;
    neg14_q <= num13[DW-1] ^ den13[DW-1];
    dz14_q  <= (den_s == '0);

    p79_q   <= tag78[1] ? -quo78 : quo78;
    dz_q    <= {dz_q[DZ_DLY-2:0], tag78[0]};

    sum84_q <= p83 + DW'($signed(t83) >>> 25) + DW'($signed(pb83) >>> 19);
    pr85_q  <= dz_q[DZ_DLY-2] ? '0 : sum84_q[39:8] + p7sh;

    tdly_q[0] <= tres8;
    for (int i = 1; i < TEMP_DLY; i++) begin
      tdly_q[i] <= tdly_q[i-1];
    end
  end

  assign done_o           = vld_q[LAT_TOTAL-1];
  assign fine_temp_o      = tdly_q[TEMP_DLY-1].fine;
  assign temp_centi_o     = tdly_q[TEMP_DLY-1].centi;
  assign temp_deg_o       = tdly_q[TEMP_DLY-1].deg;
  assign pressure_q24_8_o = pr85_q;
  assign div_zero_o       = dz_q[DZ_DLY-1];

endmodule

`default_nettype wire

@@ rtl/core/btpc_checker.sv @@
// Port-level checker for the compensation block, bound to the top level.
// Uses btpc_pkg and the assertion macros header.
`default_nettype none
`include "baro_temp_pressure_compensation_defines.svh"

module btpc_checker import btpc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [RAW_W-1:0]     raw_temp_i,
  input logic [RAW_W-1:0]     raw_pressure_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 done_o,
  input logic [31:0]          fine_temp_o,
  input logic [31:0]          temp_centi_o,
  input logic [25:0]          temp_deg_o,
  input logic [31:0]          pressure_q24_8_o,
  input logic                 div_zero_o
);

  logic signed [39:0] deg_rem;

  // remainder of the truncated division by 100
  assign deg_rem = 40'(signed'(temp_centi_o)) - 40'(signed'(temp_deg_o)) * 40'sd100;

  `BTPC_ASSERT(a_result_follows_request, start && !busy |-> ##LAT_TOTAL done_o)
  `BTPC_ASSERT(a_no_spurious_result, done_o |-> $past(start && !busy, LAT_TOTAL))
  `BTPC_ASSERT(a_zero_div_clears_press, done_o && div_zero_o |-> pressure_q24_8_o == '0)
  `BTPC_ASSERT(a_deg_matches_centi, done_o |-> deg_rem > -40'sd100 && deg_rem < 40'sd100)

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);

`default_nettype wire
